// ===== design/tpe_pkg.sv =====
// tpe_pkg: shared types and constants for the touch poll event block
// holds event and bus request codes, register indexes and stream field layout
// no dependencies
`timescale 1ns / 1ps

package tpe_pkg;

	// event reported to the host
	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_DOWN = 2'd1,
		EV_MOVE = 2'd2,
		EV_UP   = 2'd3
	} event_kind_t;

	// bus transfer requested from the controller
	typedef enum logic [1:0] {
		REQ_NONE   = 2'd0,
		REQ_STATUS = 2'd1,
		REQ_TOUCH  = 2'd2,
		REQ_CLEAR  = 2'd3
	} bus_req_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ROTATION = 2'd0,
		REG_X_EXTENT = 2'd1,
		REG_Y_EXTENT = 2'd2,
		REG_INTERVAL = 2'd3
	} reg_index_t;

	// panel orientation
	typedef enum logic [1:0] {
		ROT_LANDSCAPE      = 2'd0,
		ROT_PORTRAIT       = 2'd1,
		ROT_LANDSCAPE_FLIP = 2'd2,
		ROT_PORTRAIT_FLIP  = 2'd3
	} rotation_t;

	// event and request of one result
	typedef struct packed {
		event_kind_t kind;
		bus_req_t    req;
	} result_ctl_t;

	localparam int unsigned EXTENT_W   = 13;
	localparam int unsigned INTERVAL_W = 20;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned RAW_W      = 16;
	localparam int unsigned STATUS_W   = 8;
	localparam int unsigned CFG_DATA_W = 20;

	localparam logic [EXTENT_W-1:0]   X_EXTENT_RST = 13'd320;
	localparam logic [EXTENT_W-1:0]   Y_EXTENT_RST = 13'd480;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 20'd1000;

	// status byte: valid flag and touch count
	localparam logic [STATUS_W-1:0] STATUS_VALID = 8'h80;
	localparam logic [STATUS_W-1:0] STATUS_COUNT = 8'h0f;

	// slave tdata layout, lowest bit first
	localparam int unsigned IN_BUSY_LSB   = 0;
	localparam int unsigned IN_NOW_LSB    = 1;
	localparam int unsigned IN_OK_LSB     = 33;
	localparam int unsigned IN_STATUS_LSB = 34;
	localparam int unsigned IN_X_LSB      = 42;
	localparam int unsigned IN_Y_LSB      = 58;
	localparam int unsigned IN_DATA_W     = 80;

endpackage

// ===== design/tpe_map.sv =====
// tpe_map: clamps a raw touch point to the panel extents and rotates it
// combinational, uses tpe_pkg
`timescale 1ns / 1ps

module tpe_map #(
	parameter int unsigned COORD_WIDTH = 12
) (
	input  logic [1:0]                   rotation,
	input  logic [tpe_pkg::EXTENT_W-1:0] x_extent,
	input  logic [tpe_pkg::EXTENT_W-1:0] y_extent,
	input  logic [tpe_pkg::RAW_W-1:0]    x_raw,
	input  logic [tpe_pkg::RAW_W-1:0]    y_raw,
	output logic [COORD_WIDTH-1:0]       col,
	output logic [COORD_WIDTH-1:0]       row
);

	// wide enough for the extent and for 2^COORD_WIDTH
	localparam int unsigned EW = (COORD_WIDTH + 1 > tpe_pkg::EXTENT_W) ?
		COORD_WIDTH + 1 : tpe_pkg::EXTENT_W;
	localparam logic [EW-1:0] LIM = EW'(1) << COORD_WIDTH;

	logic [EW-1:0]          x_ext_w, y_ext_w, x_eff, y_eff, x_last, y_last;
	logic [COORD_WIDTH-1:0] x_max, y_max, x_c, y_c;

	always_comb begin
		x_ext_w = EW'(x_extent);
		y_ext_w = EW'(y_extent);
		// zero extent behaves as one, oversize extent saturates
		x_eff = (x_ext_w == '0) ? EW'(1) : ((x_ext_w > LIM) ? LIM : x_ext_w);
		y_eff = (y_ext_w == '0) ? EW'(1) : ((y_ext_w > LIM) ? LIM : y_ext_w);
		x_last = x_eff - EW'(1);
		y_last = y_eff - EW'(1);
		x_max = x_last[COORD_WIDTH-1:0];
		y_max = y_last[COORD_WIDTH-1:0];
		x_c = (x_raw > tpe_pkg::RAW_W'(x_max)) ? x_max : x_raw[COORD_WIDTH-1:0];
		y_c = (y_raw > tpe_pkg::RAW_W'(y_max)) ? y_max : y_raw[COORD_WIDTH-1:0];
		case (tpe_pkg::rotation_t'(rotation))
			tpe_pkg::ROT_LANDSCAPE: begin
				col = y_max - y_c;
				row = x_c;
			end
			tpe_pkg::ROT_PORTRAIT: begin
				col = x_c;
				row = y_c;
			end
			tpe_pkg::ROT_LANDSCAPE_FLIP: begin
				col = y_c;
				row = x_max - x_c;
			end
			default: begin
				col = x_max - x_c;
				row = y_max - y_c;
			end
		endcase
	end

endmodule

// ===== design/tpe_fsm.sv =====
// tpe_fsm: polling phase machine, deadline timer and last reported touch
// state advances once per item leaving the input register; uses tpe_pkg
`timescale 1ns / 1ps

module tpe_fsm #(
	parameter int unsigned COORD_WIDTH = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           bus_busy,
	input  logic [tpe_pkg::TIME_W-1:0]     now_us,
	input  logic                           xfer_ok,
	input  logic [tpe_pkg::STATUS_W-1:0]   status_byte,
	input  logic [COORD_WIDTH-1:0]         map_col,
	input  logic [COORD_WIDTH-1:0]         map_row,
	input  logic [tpe_pkg::INTERVAL_W-1:0] poll_interval_us,
	output tpe_pkg::result_ctl_t           res_ctl,
	output logic [COORD_WIDTH-1:0]         res_col,
	output logic [COORD_WIDTH-1:0]         res_row
);

	typedef enum logic [1:0] {
		PH_IDLE         = 2'd0,
		PH_STATUS_READ  = 2'd1,
		PH_TOUCH_READ   = 2'd2,
		PH_STATUS_WRITE = 2'd3
	} phase_t;

	phase_t                     phase_q, phase_d;
	logic [tpe_pkg::TIME_W-1:0] deadline_q, deadline_d, since;
	tpe_pkg::event_kind_t       last_kind_q, last_kind_d;
	logic [COORD_WIDTH-1:0]     last_col_q, last_col_d, last_row_q, last_row_d;

	always_comb begin
		phase_d       = phase_q;
		deadline_d    = deadline_q;
		last_kind_d   = last_kind_q;
		last_col_d    = last_col_q;
		last_row_d    = last_row_q;
		res_ctl.kind  = tpe_pkg::EV_NONE;
		res_ctl.req   = tpe_pkg::REQ_NONE;
		res_col       = '0;
		res_row       = '0;
		// wrap-safe compare: deadline reached when the difference is non-negative
		since         = now_us - deadline_q;
		if (!bus_busy) begin
			case (phase_q)
				PH_IDLE: begin
					if (!since[tpe_pkg::TIME_W-1]) begin
						res_ctl.req = tpe_pkg::REQ_STATUS;
						phase_d     = PH_STATUS_READ;
						deadline_d  = now_us + tpe_pkg::TIME_W'(poll_interval_us);
					end
				end
				PH_STATUS_READ: begin
					if (xfer_ok && ((status_byte & tpe_pkg::STATUS_VALID) != '0)) begin
						if ((status_byte & tpe_pkg::STATUS_COUNT) != '0) begin
							res_ctl.req = tpe_pkg::REQ_TOUCH;
							phase_d     = PH_TOUCH_READ;
						end else begin
							if (last_kind_q == tpe_pkg::EV_DOWN ||
								last_kind_q == tpe_pkg::EV_MOVE) begin
								last_kind_d = tpe_pkg::EV_UP;
							end else begin
								last_kind_d = tpe_pkg::EV_NONE;
								last_col_d  = '0;
								last_row_d  = '0;
							end
							res_ctl.kind = last_kind_d;
							res_col      = last_col_d;
							res_row      = last_row_d;
							res_ctl.req  = tpe_pkg::REQ_CLEAR;
							phase_d      = PH_STATUS_WRITE;
						end
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_TOUCH_READ: begin
					if (xfer_ok) begin
						if (last_kind_q == tpe_pkg::EV_NONE ||
							last_kind_q == tpe_pkg::EV_UP) begin
							last_kind_d  = tpe_pkg::EV_DOWN;
							last_col_d   = map_col;
							last_row_d   = map_row;
							res_ctl.kind = tpe_pkg::EV_DOWN;
							res_col      = map_col;
							res_row      = map_row;
						end else if (last_col_q != map_col || last_row_q != map_row) begin
							last_kind_d  = tpe_pkg::EV_MOVE;
							last_col_d   = map_col;
							last_row_d   = map_row;
							res_ctl.kind = tpe_pkg::EV_MOVE;
							res_col      = map_col;
							res_row      = map_row;
						end
					end
					res_ctl.req = tpe_pkg::REQ_CLEAR;
					phase_d     = PH_STATUS_WRITE;
				end
				default: begin
					res_ctl.req = tpe_pkg::REQ_STATUS;
					phase_d     = PH_STATUS_READ;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			deadline_q  <= '0;
			last_kind_q <= tpe_pkg::EV_NONE;
			last_col_q  <= '0;
			last_row_q  <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			deadline_q  <= deadline_d;
			last_kind_q <= last_kind_d;
			last_col_q  <= last_col_d;
			last_row_q  <= last_row_d;
		end
	end

endmodule

// ===== design/touch_poll_event_fsm.sv =====
// touch_poll_event_fsm: top level of the touch poll event block
// holds configuration, input register and result register; uses tpe_pkg,
// tpe_map and tpe_fsm
`timescale 1ns / 1ps

// usage
// - each slave stream transaction is one service call of the touch poller:
//   bus state, microsecond time, last transfer status and the raw touch point
// - each call gives exactly one master stream transaction: the event kind on
//   tuser, and the column, row and bus request to issue on tdata
// - the host carries out the requested bus transfer and reports its outcome
//   with a later call
// - an accepted call is taken into the input register; its result is loaded into
//   the result register once that register is free, and is presented from there
// - throughput: one call per cycle while the receiver keeps taking results; the
//   poller state is a single update between the two registers
// - a full input register still accepts a new call in the cycle the result
//   register is free or drained, so a stalled receiver holds both registers
//   and tready falls only when both are full
// - reset: phase idle, deadline zero, no touch remembered, registers back to
//   landscape, 320 by 480, 1000 us interval; both stages empty
// - configuration writes go straight to the registers and are meant for
//   quiet periods with no calls in flight

module touch_poll_event_fsm #(
	parameter int unsigned COORD_WIDTH = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_wen,
	input  logic [1:0]                           cfg_index,
	input  logic [tpe_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	// service calls
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// bus_busy, now_us, xfer_ok, status_byte, touch_x_raw, touch_y_raw, zero pad
	input  logic [tpe_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// results
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// event_col, event_row, bus_request, zero pad
	output logic [((2*COORD_WIDTH+2+7)/8)*8-1:0] m_axis_tdata,
	// event_kind
	output logic [1:0]                           m_axis_tuser
);

	localparam int unsigned OUT_W  = ((2 * COORD_WIDTH + 2 + 7) / 8) * 8;
	localparam int unsigned PACK_W = 2 * COORD_WIDTH + 2;

	// configuration registers
	logic [1:0]                     rotation_q;
	logic [tpe_pkg::EXTENT_W-1:0]   x_extent_q, y_extent_q;
	logic [tpe_pkg::INTERVAL_W-1:0] interval_q;

	// input stage
	logic                           valid_s1;
	logic                           busy_s1, ok_s1;
	logic [tpe_pkg::TIME_W-1:0]     now_s1;
	logic [tpe_pkg::STATUS_W-1:0]   status_s1;
	logic [tpe_pkg::RAW_W-1:0]      x_raw_s1, y_raw_s1;

	// result stage
	logic                           valid_s2;
	tpe_pkg::result_ctl_t           ctl_s2;
	logic [COORD_WIDTH-1:0]         col_s2, row_s2;

	logic                           advance, in_take;
	logic [COORD_WIDTH-1:0]         map_col, map_row, res_col, res_row;
	tpe_pkg::result_ctl_t           res_ctl;
	logic [OUT_W-1:0]               out_data;

	// result register frees when empty or being taken; input stage moves then
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= 2'd0;
			x_extent_q <= tpe_pkg::X_EXTENT_RST;
			y_extent_q <= tpe_pkg::Y_EXTENT_RST;
			interval_q <= tpe_pkg::INTERVAL_RST;
		end else if (cfg_wen) begin
			case (tpe_pkg::reg_index_t'(cfg_index))
				tpe_pkg::REG_ROTATION: rotation_q <= cfg_wdata[1:0];
				tpe_pkg::REG_X_EXTENT: x_extent_q <= cfg_wdata[tpe_pkg::EXTENT_W-1:0];
				tpe_pkg::REG_Y_EXTENT: y_extent_q <= cfg_wdata[tpe_pkg::EXTENT_W-1:0];
				tpe_pkg::REG_INTERVAL: interval_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register: control bit under reset, payload loads on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			busy_s1   <= s_axis_tdata[tpe_pkg::IN_BUSY_LSB];
			now_s1    <= s_axis_tdata[tpe_pkg::IN_NOW_LSB +: tpe_pkg::TIME_W];
			ok_s1     <= s_axis_tdata[tpe_pkg::IN_OK_LSB];
			status_s1 <= s_axis_tdata[tpe_pkg::IN_STATUS_LSB +: tpe_pkg::STATUS_W];
			x_raw_s1  <= s_axis_tdata[tpe_pkg::IN_X_LSB +: tpe_pkg::RAW_W];
			y_raw_s1  <= s_axis_tdata[tpe_pkg::IN_Y_LSB +: tpe_pkg::RAW_W];
		end
	end

	tpe_map #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_map (
		.rotation (rotation_q),
		.x_extent (x_extent_q),
		.y_extent (y_extent_q),
		.x_raw    (x_raw_s1),
		.y_raw    (y_raw_s1),
		.col      (map_col),
		.row      (map_row)
	);

	// poller state commits exactly when the input stage hands its call on
	tpe_fsm #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_fsm (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (valid_s1 && advance),
		.bus_busy         (busy_s1),
		.now_us           (now_s1),
		.xfer_ok          (ok_s1),
		.status_byte      (status_s1),
		.map_col          (map_col),
		.map_row          (map_row),
		.poll_interval_us (interval_q),
		.res_ctl          (res_ctl),
		.res_col          (res_col),
		.res_row          (res_row)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			ctl_s2 <= res_ctl;
			col_s2 <= res_col;
			row_s2 <= res_row;
		end
	end

	always_comb begin
		out_data             = '0;
		out_data[PACK_W-1:0] = {ctl_s2.req, row_s2, col_s2};
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = out_data;
	assign m_axis_tuser  = ctl_s2.kind;

endmodule

// ===== sim/touch_event_checker.sv =====
// touch_event_checker: watches the configuration port and both streams of the
// touch poll event block, predicts every result and compares it field by field
// depends on tpe_pkg for codes, register indexes and the input field layout
`timescale 1ns / 1ps

module touch_event_checker #(
	parameter int unsigned COORD_WIDTH = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [1:0]                           cfg_index,
	input  logic [tpe_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                 s_axis_tvalid,
	input  logic                                 s_axis_tready,
	// bus_busy, now_us, xfer_ok, status_byte, touch_x_raw, touch_y_raw, zero pad
	input  logic [tpe_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	input  logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// event_col, event_row, bus_request, zero pad
	input  logic [((2*COORD_WIDTH+2+7)/8)*8-1:0] m_axis_tdata,
	// event_kind
	input  logic [1:0]                           m_axis_tuser,
	output int unsigned                          fail_count,
	output int unsigned                          pending
);
	import tpe_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_STATUS = 2'd1,
		PH_TOUCH  = 2'd2,
		PH_CLEAR  = 2'd3
	} poll_phase_t;

	typedef struct packed {
		event_kind_t            kind;
		logic [COORD_WIDTH-1:0] col;
		logic [COORD_WIDTH-1:0] row;
		bus_req_t               req;
	} touch_result_t;

	// configuration copy
	rotation_t               rot;
	logic [EXTENT_W-1:0]     x_ext;
	logic [EXTENT_W-1:0]     y_ext;
	logic [INTERVAL_W-1:0]   poll_gap;

	// poller state copy
	poll_phase_t             phase;
	logic [TIME_W-1:0]       deadline;
	event_kind_t             held_kind;
	logic [COORD_WIDTH-1:0]  held_col;
	logic [COORD_WIDTH-1:0]  held_row;

	touch_result_t           events_due[$];
	touch_result_t           want;
	touch_result_t           have;
	int unsigned             result_no;

	function automatic int unsigned usable_extent(input logic [EXTENT_W-1:0] e);
		if (e == 0)
			return 1;
		if (e > (1 << COORD_WIDTH))
			return 1 << COORD_WIDTH;
		return e;
	endfunction

	// one service call: advances the state copy and gives the expected result
	function automatic touch_result_t service_call(input logic [IN_DATA_W-1:0] word);
		logic                  busy;
		logic                  ok;
		logic [TIME_W-1:0]     now;
		logic [TIME_W-1:0]     since;
		logic [STATUS_W-1:0]   status;
		int unsigned           xr, yr, xmax, ymax, xc, yc, col, row;
		touch_result_t         res;

		busy   = word[IN_BUSY_LSB];
		now    = word[IN_NOW_LSB +: TIME_W];
		ok     = word[IN_OK_LSB];
		status = word[IN_STATUS_LSB +: STATUS_W];
		xr     = word[IN_X_LSB +: RAW_W];
		yr     = word[IN_Y_LSB +: RAW_W];
		res    = '{kind: EV_NONE, col: '0, row: '0, req: REQ_NONE};

		if (!busy) begin
			case (phase)
			PH_IDLE: begin
				// wrap-safe: poll once now is not behind the deadline
				since = now - deadline;
				if (!since[TIME_W-1]) begin
					res.req  = REQ_STATUS;
					phase    = PH_STATUS;
					deadline = now + TIME_W'(poll_gap);
				end
			end
			PH_STATUS: begin
				if (ok && (status & STATUS_VALID) != 0) begin
					if ((status & STATUS_COUNT) != 0) begin
						res.req = REQ_TOUCH;
						phase   = PH_TOUCH;
					end else begin
						if (held_kind == EV_DOWN || held_kind == EV_MOVE) begin
							held_kind = EV_UP;
						end else begin
							held_kind = EV_NONE;
							held_col  = '0;
							held_row  = '0;
						end
						res.kind = held_kind;
						res.col  = held_col;
						res.row  = held_row;
						res.req  = REQ_CLEAR;
						phase    = PH_CLEAR;
					end
				end else begin
					phase = PH_IDLE;
				end
			end
			PH_TOUCH: begin
				if (ok) begin
					xmax = usable_extent(x_ext) - 1;
					ymax = usable_extent(y_ext) - 1;
					xc   = (xr > xmax) ? xmax : xr;
					yc   = (yr > ymax) ? ymax : yr;
					case (rot)
					ROT_LANDSCAPE: begin
						col = ymax - yc;
						row = xc;
					end
					ROT_PORTRAIT: begin
						col = xc;
						row = yc;
					end
					ROT_LANDSCAPE_FLIP: begin
						col = yc;
						row = xmax - xc;
					end
					default: begin
						col = xmax - xc;
						row = ymax - yc;
					end
					endcase
					if (held_kind == EV_NONE || held_kind == EV_UP) begin
						held_kind = EV_DOWN;
						held_col  = COORD_WIDTH'(col);
						held_row  = COORD_WIDTH'(row);
						res.kind  = EV_DOWN;
						res.col   = held_col;
						res.row   = held_row;
					end else if (held_col != COORD_WIDTH'(col) ||
							held_row != COORD_WIDTH'(row)) begin
						held_kind = EV_MOVE;
						held_col  = COORD_WIDTH'(col);
						held_row  = COORD_WIDTH'(row);
						res.kind  = EV_MOVE;
						res.col   = held_col;
						res.row   = held_row;
					end
				end
				res.req = REQ_CLEAR;
				phase   = PH_CLEAR;
			end
			default: begin
				res.req = REQ_STATUS;
				phase   = PH_STATUS;
			end
			endcase
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at result %0d: %s", result_no, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot        = ROT_LANDSCAPE;
			x_ext      = X_EXTENT_RST;
			y_ext      = Y_EXTENT_RST;
			poll_gap   = INTERVAL_RST;
			phase      = PH_IDLE;
			deadline   = '0;
			held_kind  = EV_NONE;
			held_col   = '0;
			held_row   = '0;
			result_no  = 0;
			fail_count = 0;
			events_due.delete();
			pending <= 0;
		end else begin
			if (cfg_wen) begin
				case (reg_index_t'(cfg_index))
				REG_ROTATION: rot      = rotation_t'(cfg_wdata[1:0]);
				REG_X_EXTENT: x_ext    = cfg_wdata[EXTENT_W-1:0];
				REG_Y_EXTENT: y_ext    = cfg_wdata[EXTENT_W-1:0];
				REG_INTERVAL: poll_gap = cfg_wdata[INTERVAL_W-1:0];
				default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				result_no++;
				have.kind = event_kind_t'(m_axis_tuser);
				have.col  = m_axis_tdata[COORD_WIDTH-1:0];
				have.row  = m_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
				have.req  = bus_req_t'(m_axis_tdata[2*COORD_WIDTH+1:2*COORD_WIDTH]);
				if (events_due.size() == 0) begin
					report_mismatch($sformatf("result with no call outstanding (kind %0d req %0d)",
						have.kind, have.req));
				end else begin
					want = events_due.pop_front();
					if (have.kind !== want.kind)
						report_mismatch($sformatf("event_kind %0d, expected %0d",
							have.kind, want.kind));
					if (have.col !== want.col)
						report_mismatch($sformatf("event_col %0d, expected %0d",
							have.col, want.col));
					if (have.row !== want.row)
						report_mismatch($sformatf("event_row %0d, expected %0d",
							have.row, want.row));
					if (have.req !== want.req)
						report_mismatch($sformatf("bus_request %0d, expected %0d",
							have.req, want.req));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				events_due.push_back(service_call(s_axis_tdata));
			pending <= events_due.size();
		end
	end

endmodule

// ===== sim/tb_touch_poll_event_fsm.sv =====
// tb_touch_poll_event_fsm: stimulus and verdict for the touch poll event block
// depends on tpe_pkg, touch_poll_event_fsm and touch_event_checker
`timescale 1ns / 1ps

module tb_touch_poll_event_fsm;
	import tpe_pkg::*;

	localparam int unsigned COORD_WIDTH       = 12;
	localparam int unsigned OUT_W             = ((2*COORD_WIDTH+2+7)/8)*8;
	// slowest correct run is well under this even with every long gap and stall
	localparam int unsigned CYCLE_LIMIT       = 1000000;
	localparam int unsigned CALLS_PER_SETTING = 230;
	localparam int unsigned SETTINGS_COUNT    = 6;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_wen       = 1'b0;
	logic [1:0]            cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic [1:0]            m_axis_tuser;

	int unsigned           fail_count;
	int unsigned           pending;
	int unsigned           cycle_count = 0;

	// stimulus-side view of time and of the settings last written
	logic [TIME_W-1:0]     clock_us;
	logic [INTERVAL_W-1:0] interval_cur;
	logic [EXTENT_W-1:0]   x_ext_cur;
	logic [EXTENT_W-1:0]   y_ext_cur;
	logic [RAW_W-1:0]      last_x;
	logic [RAW_W-1:0]      last_y;

	// sender idling: stretches of gap-free offers are mixed at random with gappy ones
	int unsigned           tx_stretch = 0;
	bit                    tx_quiet   = 1'b0;
	// asks the receiver for one long hold-off
	bit                    rx_hold_req = 1'b0;

	always #6 clk = ~clk;

	touch_poll_event_fsm #(
		.COORD_WIDTH (COORD_WIDTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	touch_event_checker #(
		.COORD_WIDTH (COORD_WIDTH)
	) event_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: short and long stalls, calm stretches, and one long hold-off on request
	initial begin : receiver
		int unsigned hold_left;
		int unsigned stall_left;
		int unsigned stretch_left;
		int unsigned r;
		bit          calm;

		hold_left    = 0;
		stall_left   = 0;
		stretch_left = 0;
		calm         = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_hold_req) begin
				// long hold-off so both stages fill and the input stalls
				rx_hold_req = 1'b0;
				hold_left   = $urandom_range(40, 80);
				m_axis_tready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(20, 200);
					calm         = ($urandom_range(0, 2) == 0);
				end
				stretch_left--;
				r = $urandom_range(0, 99);
				if (calm || r < 70) begin
					m_axis_tready <= 1'b1;
				end else if (r < 95) begin
					stall_left = $urandom_range(0, 3);
					m_axis_tready <= 1'b0;
				end else begin
					stall_left = $urandom_range(8, 40);
					m_axis_tready <= 1'b0;
				end
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;

		if (tx_stretch == 0) begin
			tx_stretch = $urandom_range(20, 150);
			tx_quiet   = ($urandom_range(0, 3) == 0);
		end
		tx_stretch--;
		if (tx_quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// offer one service call and wait for its transaction; valid stays high
	// into the next call when no gap is chosen
	task automatic send_call(input logic busy, input logic [TIME_W-1:0] now,
			input logic ok, input logic [STATUS_W-1:0] status,
			input logic [RAW_W-1:0] xr, input logic [RAW_W-1:0] yr, input bit burst);
		logic [IN_DATA_W-1:0] word;
		int unsigned          gap;

		word = '0;
		word[IN_BUSY_LSB]               = busy;
		word[IN_NOW_LSB +: TIME_W]      = now;
		word[IN_OK_LSB]                 = ok;
		word[IN_STATUS_LSB +: STATUS_W] = status;
		word[IN_X_LSB +: RAW_W]         = xr;
		word[IN_Y_LSB +: RAW_W]         = yr;
		gap = burst ? 0 : pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// random call with mostly sane content: time moving forward past the
	// deadline, valid status, touches near the panel and repeated positions
	task automatic send_random_call(input bit burst);
		logic                busy;
		logic                ok;
		logic [TIME_W-1:0]   now;
		logic [STATUS_W-1:0] status;
		logic [RAW_W-1:0]    xr;
		logic [RAW_W-1:0]    yr;
		int unsigned         r;

		busy = ($urandom_range(0, 99) < 10);
		r = $urandom_range(0, 99);
		if (r < 4) begin
			// stray timestamp, the running time is left alone
			now = $urandom;
		end else if (r < 6) begin
			// big jump forward, still less than half the range past the deadline
			clock_us = clock_us + 32'h7000_0000;
			now      = clock_us;
		end else if (r < 12) begin
			// time steps back a little
			clock_us = clock_us - $urandom_range(0, interval_cur);
			now      = clock_us;
		end else begin
			clock_us = clock_us + $urandom_range(0, 2 * interval_cur + 2);
			now      = clock_us;
		end
		ok = ($urandom_range(0, 99) < 92);
		r = $urandom_range(0, 99);
		status = STATUS_W'($urandom);
		if (r < 82) begin
			status[7] = 1'b1;
			if (r < 30)
				status[3:0] = 4'h0;
			else if (status[3:0] == 4'h0)
				status[3:0] = 4'h1;
		end
		r = $urandom_range(0, 99);
		if (r < 30) begin
			xr = last_x;
			yr = last_y;
		end else if (r < 80) begin
			xr = RAW_W'($urandom_range(0, x_ext_cur + 8));
			yr = RAW_W'($urandom_range(0, y_ext_cur + 8));
		end else begin
			xr = RAW_W'($urandom);
			yr = RAW_W'($urandom);
		end
		last_x = xr;
		last_y = yr;
		send_call(busy, now, ok, status, xr, yr, burst);
	endtask

	// stop offering and wait until every expected result has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic put_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// write all four registers back to back; unused upper bits get noise
	task automatic apply_settings(input rotation_t rot, input logic [EXTENT_W-1:0] xe,
			input logic [EXTENT_W-1:0] ye, input logic [INTERVAL_W-1:0] iv);
		put_reg(REG_ROTATION, {(CFG_DATA_W-2)'($urandom), rot});
		put_reg(REG_X_EXTENT, {7'($urandom), xe});
		put_reg(REG_Y_EXTENT, {7'($urandom), ye});
		put_reg(REG_INTERVAL, iv);
		cfg_wen <= 1'b0;
		x_ext_cur    = xe;
		y_ext_cur    = ye;
		interval_cur = iv;
	endtask

	initial begin : stimulus
		logic [TIME_W-1:0] t;
		int unsigned       n;
		int unsigned       p;

		clock_us     = '0;
		interval_cur = INTERVAL_RST;
		x_ext_cur    = X_EXTENT_RST;
		y_ext_cur    = Y_EXTENT_RST;
		last_x       = '0;
		last_y       = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk through every phase with reset settings
		t = 32'h8000_07cf;
		// busy bus with every other field at its top value
		send_call(1'b1, '1, 1'b1, 8'hff, 16'hffff, 16'hffff, 1'b0);
		// time exactly at the deadline polls
		send_call(1'b0, 32'd0, 1'b1, 8'h81, 16'h0000, 16'h0000, 1'b0);
		// failed status read drops back to idle
		send_call(1'b0, 32'd0, 1'b0, 8'h81, 16'h0000, 16'h0000, 1'b0);
		// one short of the deadline waits
		send_call(1'b0, 32'd999, 1'b1, 8'h81, 16'h0000, 16'h0000, 1'b0);
		send_call(1'b0, 32'd1000, 1'b1, 8'h81, 16'h0000, 16'h0000, 1'b0);
		// status without the valid flag
		send_call(1'b0, 32'd1000, 1'b1, 8'h7f, 16'h0000, 16'h0000, 1'b0);
		// half the range ahead reads as behind, one less polls
		send_call(1'b0, 32'h8000_07d0, 1'b1, 8'h81, 16'h0000, 16'h0000, 1'b0);
		send_call(1'b0, t, 1'b1, 8'h81, 16'h0000, 16'h0000, 1'b0);
		// zero count with nothing held: none and position cleared
		send_call(1'b0, t, 1'b1, 8'h80, 16'h0000, 16'h0000, 1'b0);
		// busy bus while the clear is due
		send_call(1'b1, t, 1'b1, 8'h80, 16'h0000, 16'h0000, 1'b0);
		send_call(1'b0, t, 1'b1, 8'h00, 16'h0000, 16'h0000, 1'b0);
		// full count, then a touch clamped at the panel edge
		send_call(1'b0, t, 1'b1, 8'h8f, 16'hffff, 16'hffff, 1'b0);
		send_call(1'b0, t, 1'b1, 8'h00, 16'hffff, 16'hffff, 1'b0);
		send_call(1'b0, t, 1'b1, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_call(1'b0, t, 1'b1, 8'h81, 16'h0000, 16'h0000, 1'b0);
		// same position again: no event
		send_call(1'b0, t, 1'b1, 8'h81, 16'hffff, 16'hffff, 1'b0);
		send_call(1'b0, t, 1'b1, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_call(1'b0, t, 1'b1, 8'hff, 16'h0000, 16'h0000, 1'b0);
		// moved to the origin
		send_call(1'b0, t, 1'b1, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_call(1'b0, t, 1'b1, 8'h00, 16'h0000, 16'h0000, 1'b0);
		send_call(1'b0, t, 1'b1, 8'h81, 16'h0000, 16'h0000, 1'b0);
		// failed touch read still asks for the clear
		send_call(1'b0, t, 1'b0, 8'h81, 16'h1234, 16'h0321, 1'b0);
		send_call(1'b0, t, 1'b1, 8'h00, 16'h0000, 16'h0000, 1'b0);
		// touch lifted: up at the last position
		send_call(1'b0, t, 1'b1, 8'h80, 16'h0000, 16'h0000, 1'b0);
		send_call(1'b0, t, 1'b1, 8'h00, 16'h0000, 16'h0000, 1'b0);
		// still lifted: none
		send_call(1'b0, t, 1'b1, 8'h80, 16'h0000, 16'h0000, 1'b0);
		clock_us = t;

		for (p = 0; p < SETTINGS_COUNT; p++) begin
			if (p != 0) begin
				wait_drained();
				case (p)
				1: apply_settings(ROT_PORTRAIT, 13'd1, 13'd4096, 20'd1);
				2: apply_settings(ROT_LANDSCAPE_FLIP, 13'd4096, 13'd1, 20'd1000000);
				// zero and oversized extents, interval of zero
				3: apply_settings(ROT_PORTRAIT_FLIP, 13'd0, 13'd8191, 20'd0);
				4: apply_settings(rotation_t'($urandom_range(0, 3)),
					EXTENT_W'($urandom_range(1, 4096)),
					EXTENT_W'($urandom_range(1, 4096)),
					INTERVAL_W'($urandom_range(1, 2000)));
				default: apply_settings(ROT_LANDSCAPE, 13'd4097, 13'd2, 20'd50);
				endcase
			end
			for (n = 0; n < CALLS_PER_SETTING; n++) begin
				if (n == 100 && (p == 1 || p == 4)) begin
					// receiver holds off while calls keep coming back to back
					rx_hold_req = 1'b1;
					repeat (24) send_random_call(1'b1);
				end
				if (n == 150 && p == 2)
					wait_drained();
				send_random_call(1'b0);
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
design/tpe_pkg.sv
design/tpe_map.sv
design/tpe_fsm.sv
design/touch_poll_event_fsm.sv
sim/touch_event_checker.sv
sim/tb_touch_poll_event_fsm.sv
